### rtl/core/pcewma_pkg.sv
// Shared constants, codes and types for the per-cohort EWMA indicator table.
// Depends on nothing; imported by the table's top level.
`default_nettype none

package pcewma_pkg;

	// Table geometry and fixed-point formats.
	localparam int COHORTS  = 64;
	localparam int COHORT_W = $clog2(COHORTS);
	localparam int DATA_W   = 16;
	localparam int LANES    = 4;
	localparam int LANE_W   = $clog2(LANES);
	localparam int WORD_W   = LANES * DATA_W;
	localparam int FRAC_W   = 15;

	localparam logic [DATA_W-1:0] ONE_Q15     = 16'd32768;
	localparam logic [DATA_W-1:0] ALPHA_RESET = 16'd6554;

	// Lane order inside a stored word, lowest lane in the lowest bits.
	localparam logic [LANE_W-1:0] LANE_ENTROPY  = 2'd0;
	localparam logic [LANE_W-1:0] LANE_MARGIN   = 2'd1;
	localparam logic [LANE_W-1:0] LANE_DISAGREE = 2'd2;
	localparam logic [LANE_W-1:0] LANE_ABSTAIN  = 2'd3;

	// Command codes; the unused code behaves as a read.
	typedef enum logic [1:0] {
		CMD_REQUEST = 2'd0,
		CMD_SHADOW  = 2'd1,
		CMD_READ    = 2'd2
	} cmd_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### rtl/core/pcewma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the cohort average store.
`default_nettype none

module pcewma_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/per_cohort_ewma_indicator_table.sv
// Per-cohort EWMA indicator table: four running averages and a seen flag per cohort.
// A command is taken only while idle. A read or a first update passes ST_LOAD and ST_DONE;
// a blended update goes ST_LOAD, then ST_MUL and ST_ADD for each of the four lanes on one
// shared multiplier, then ST_DONE. No new command is taken until done has been given.
// Reset clears the seen flags and loads 6554 as smoothing factor; unseen cohorts read zero.
// Results cannot be stalled: done lasts one cycle. Depends on pcewma_pkg and pcewma_ram.
`default_nettype none

module per_cohort_ewma_indicator_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration write.
	input  wire logic                           smoothing_factor_we,
	input  wire logic [pcewma_pkg::DATA_W-1:0]  smoothing_factor,
	// Command channel.
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     command,
	input  wire logic [5:0]                     cohort,
	input  wire logic [pcewma_pkg::DATA_W-1:0]  entropy_in,
	input  wire logic [pcewma_pkg::DATA_W-1:0]  margin_in,
	input  wire logic                           abstained,
	input  wire logic [pcewma_pkg::DATA_W-1:0]  champion_label,
	input  wire logic [pcewma_pkg::DATA_W-1:0]  challenger_label,
	// Result channel.
	output logic                                done,
	output logic [pcewma_pkg::DATA_W-1:0]       entropy_avg,
	output logic [pcewma_pkg::DATA_W-1:0]       margin_avg,
	output logic [pcewma_pkg::DATA_W-1:0]       disagree_avg,
	output logic [pcewma_pkg::DATA_W-1:0]       abstain_avg,
	output logic                                seen
);

	import pcewma_pkg::*;

	state_t state_q, state_d;

	logic [DATA_W-1:0]   alpha_q;
	logic [DATA_W-1:0]   alpha_eff;
	logic [COHORTS-1:0]  seen_q;

	logic [COHORT_W-1:0] idx_q;
	logic                upd_q;
	logic                shadow_q;
	logic                seen_out_q;
	logic [DATA_W-1:0]   ent_in_q;
	logic [DATA_W-1:0]   mar_in_q;
	logic                abst_q;
	logic                differ_q;
	logic [LANE_W-1:0]   lane_q;

	logic [DATA_W-1:0]   avg_q [LANES];
	logic [DATA_W-1:0]   x_q   [LANES];
	logic signed [2*DATA_W+1:0] prod_q;

	logic                accept;
	logic                ram_we;
	logic [WORD_W-1:0]   ram_wdata;
	logic [WORD_W-1:0]   ram_rdata;

	logic                entry_seen;
	logic [DATA_W-1:0]   cur   [LANES];
	logic [DATA_W-1:0]   x_new [LANES];

	logic signed [DATA_W:0]       diff;
	logic signed [2*DATA_W+1:0]   rounded;
	logic signed [DATA_W+1:0]     delta;
	logic [DATA_W+1:0]            blend_sum;

	assign accept = start && !busy;

	// Smoothing factor register; values above one are used as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (smoothing_factor_we) begin
			alpha_q <= smoothing_factor;
		end
	end

	assign alpha_eff = (alpha_q > ONE_Q15) ? ONE_Q15 : alpha_q;

	// Average store, one word of four lanes per cohort.
	pcewma_ram #(
		.WIDTH(WORD_W),
		.DEPTH(COHORTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (cohort[COHORT_W-1:0]),
		.rdata (ram_rdata)
	);

	// Unpack the read word, hide unseen entries and form the values fed in.
	always_comb begin
		entry_seen = seen_q[idx_q];
		for (int i = 0; i < LANES; i++) begin
			cur[i] = entry_seen ? ram_rdata[i*DATA_W +: DATA_W] : '0;
		end
		if (shadow_q) begin
			x_new[LANE_ENTROPY]  = cur[LANE_ENTROPY];
			x_new[LANE_MARGIN]   = cur[LANE_MARGIN];
			x_new[LANE_DISAGREE] = differ_q ? ONE_Q15 : '0;
			x_new[LANE_ABSTAIN]  = cur[LANE_ABSTAIN];
		end else begin
			x_new[LANE_ENTROPY]  = ent_in_q;
			x_new[LANE_MARGIN]   = mar_in_q;
			x_new[LANE_DISAGREE] = '0;
			x_new[LANE_ABSTAIN]  = abst_q ? ONE_Q15 : '0;
		end
	end

	// Shared blend unit: a registered multiply in ST_MUL, then a round-and-add in ST_ADD.
	always_comb begin
		diff      = $signed({1'b0, x_q[lane_q]}) - $signed({1'b0, avg_q[lane_q]});
		rounded   = prod_q + $signed((2*DATA_W+2)'(1 << (FRAC_W - 1)));
		rounded   = rounded >>> FRAC_W;
		delta     = rounded[DATA_W+1:0];
		blend_sum = {2'b00, avg_q[lane_q]} + delta;
	end

	// Pack the lanes for the write-back.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ram_wdata[i*DATA_W +: DATA_W] = avg_q[i];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		ram_we  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = (upd_q && entry_seen) ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = (lane_q == LANE_W'(LANES - 1)) ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				done    = 1'b1;
				ram_we  = upd_q;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Seen flags are control state and clear at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (state_q == ST_DONE && upd_q) begin
			seen_q[idx_q] <= 1'b1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_q    <= cohort[COHORT_W-1:0];
					ent_in_q <= entropy_in;
					mar_in_q <= margin_in;
					abst_q   <= abstained;
					differ_q <= (champion_label != challenger_label);
					case (cmd_t'(command))
						CMD_REQUEST: begin
							upd_q    <= 1'b1;
							shadow_q <= 1'b0;
						end
						CMD_SHADOW: begin
							upd_q    <= 1'b1;
							shadow_q <= 1'b1;
						end
						default: begin
							upd_q    <= 1'b0;
							shadow_q <= 1'b0;
						end
					endcase
				end
			end
			ST_LOAD: begin
				for (int i = 0; i < LANES; i++) begin
					avg_q[i] <= (upd_q && !entry_seen) ? x_new[i] : cur[i];
					x_q[i]   <= x_new[i];
				end
				seen_out_q <= entry_seen || upd_q;
				lane_q     <= '0;
			end
			ST_MUL: begin
				prod_q <= diff * $signed({1'b0, alpha_eff});
			end
			ST_ADD: begin
				avg_q[lane_q] <= blend_sum[DATA_W-1:0];
				lane_q        <= lane_q + LANE_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Result ports show the finished entry while done is high.
	assign entropy_avg  = avg_q[LANE_ENTROPY];
	assign margin_avg   = avg_q[LANE_MARGIN];
	assign disagree_avg = avg_q[LANE_DISAGREE];
	assign abstain_avg  = avg_q[LANE_ABSTAIN];
	assign seen         = seen_out_q;

endmodule

`default_nettype wire

### rtl/core/pcewma_checker.sv
// Port-level checks for the per-cohort EWMA indicator table, with its bind.
// Depends only on the top level's port list.
`default_nettype none

module pcewma_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [15:0] entropy_avg,
	input wire logic [15:0] margin_avg,
	input wire logic [15:0] disagree_avg,
	input wire logic [15:0] abstain_avg,
	input wire logic        seen
);

	// An accepted command makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after an accepted command");

	// No result appears in the cycle right after a transfer in.
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobe too early");

	// A result belongs to a command in flight, and frees the block afterward.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block still busy after result transfer");

	// An unseen cohort always reports all-zero averages.
	a_unseen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !seen |-> entropy_avg == 16'd0 && margin_avg == 16'd0 &&
			disagree_avg == 16'd0 && abstain_avg == 16'd0)
		else $error("unseen cohort reported nonzero averages");

endmodule

bind per_cohort_ewma_indicator_table pcewma_checker u_pcewma_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.entropy_avg  (entropy_avg),
	.margin_avg   (margin_avg),
	.disagree_avg (disagree_avg),
	.abstain_avg  (abstain_avg),
	.seen         (seen)
);

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the per-cohort EWMA indicator table.
// Drives a directed table and then random phases of commands under several smoothing factors,
// predicts each cohort's averages locally; depends on pcewma_pkg and the table's RTL.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcewma_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 15;
	localparam int PHASE_ITEMS = 79;

	// One command transfer as the block sees it.
	typedef struct packed {
		logic [1:0]          cmd;
		logic [COHORT_W-1:0] cohort;
		logic [DATA_W-1:0]   entropy;
		logic [DATA_W-1:0]   margin;
		logic                abstained;
		logic [DATA_W-1:0]   champion;
		logic [DATA_W-1:0]   challenger;
	} obs_t;

	// One result: an entry's averages after the step.
	typedef struct packed {
		logic [DATA_W-1:0] entropy;
		logic [DATA_W-1:0] margin;
		logic [DATA_W-1:0] disagree;
		logic [DATA_W-1:0] abstain;
		logic              seen;
	} avgs_t;

	// A directed row is either a smoothing factor write or a command.
	typedef struct packed {
		logic              is_cfg;
		logic [DATA_W-1:0] alpha;
		obs_t              obs;
		logic              typed;
		avgs_t             want;
	} row_t;

	localparam avgs_t NO_WANT = '0;

	logic              clk;
	logic              arst_n;
	logic              smoothing_factor_we;
	logic [DATA_W-1:0] smoothing_factor;
	logic              start;
	logic              busy;
	logic [1:0]        command;
	logic [5:0]        cohort;
	logic [DATA_W-1:0] entropy_in;
	logic [DATA_W-1:0] margin_in;
	logic              abstained;
	logic [DATA_W-1:0] champion_label;
	logic [DATA_W-1:0] challenger_label;
	logic              done;
	logic [DATA_W-1:0] entropy_avg;
	logic [DATA_W-1:0] margin_avg;
	logic [DATA_W-1:0] disagree_avg;
	logic [DATA_W-1:0] abstain_avg;
	logic              seen;

	per_cohort_ewma_indicator_table u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.smoothing_factor_we (smoothing_factor_we),
		.smoothing_factor    (smoothing_factor),
		.start               (start),
		.busy                (busy),
		.command             (command),
		.cohort              (cohort),
		.entropy_in          (entropy_in),
		.margin_in           (margin_in),
		.abstained           (abstained),
		.champion_label      (champion_label),
		.challenger_label    (challenger_label),
		.done                (done),
		.entropy_avg         (entropy_avg),
		.margin_avg          (margin_avg),
		.disagree_avg        (disagree_avg),
		.abstain_avg         (abstain_avg),
		.seen                (seen)
	);

	// Local copy of the table and the smoothing factor.
	logic [DATA_W-1:0] table_entropy [COHORTS];
	logic [DATA_W-1:0] table_margin [COHORTS];
	logic [DATA_W-1:0] table_disagree [COHORTS];
	logic [DATA_W-1:0] table_abstain [COHORTS];
	logic              table_seen [COHORTS];
	logic [DATA_W-1:0] cur_alpha;

	avgs_t expected_avgs[$];
	row_t  directed_rows[$];

	int errors = 0;
	int results_checked = 0;
	int requests_sent = 0;
	int shadows_sent = 0;
	int reads_sent = 0;
	int alpha_writes = 0;
	int stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One EWMA step: avg + round(alpha * (x - avg)), ties toward plus infinity.
	function automatic logic [DATA_W-1:0] blend_toward(input logic [DATA_W-1:0] avg,
			input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] alpha);
		longint xs;
		longint as;
		longint al;
		longint prod;
		longint r;
		xs = x;
		as = avg;
		al = (alpha > ONE_Q15) ? longint'(ONE_Q15) : longint'(alpha);
		prod = (xs - as) * al + 16384;
		r = as + (prod >>> FRAC_W);
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		return r[DATA_W-1:0];
	endfunction

	// Applies one command to the local table and returns the entry afterward.
	function automatic avgs_t predict_averages(input obs_t o);
		logic [COHORT_W-1:0] k;
		logic              feed;
		logic [DATA_W-1:0] xe;
		logic [DATA_W-1:0] xm;
		logic [DATA_W-1:0] xd;
		logic [DATA_W-1:0] xa;
		avgs_t             r;
		k = o.cohort;
		feed = 1'b1;
		xe = '0;
		xm = '0;
		xd = '0;
		xa = '0;
		if (o.cmd == CMD_REQUEST) begin
			xe = o.entropy;
			xm = o.margin;
			xa = o.abstained ? ONE_Q15 : '0;
		end else if (o.cmd == CMD_SHADOW) begin
			xe = table_entropy[k];
			xm = table_margin[k];
			xa = table_abstain[k];
			xd = (o.champion != o.challenger) ? ONE_Q15 : '0;
		end else begin
			feed = 1'b0;
		end
		if (feed && !table_seen[k]) begin
			// First update of an entry loads the fed values as they are.
			table_entropy[k] = xe;
			table_margin[k] = xm;
			table_disagree[k] = xd;
			table_abstain[k] = xa;
			table_seen[k] = 1'b1;
		end else if (feed) begin
			table_entropy[k] = blend_toward(table_entropy[k], xe, cur_alpha);
			table_margin[k] = blend_toward(table_margin[k], xm, cur_alpha);
			table_disagree[k] = blend_toward(table_disagree[k], xd, cur_alpha);
			table_abstain[k] = blend_toward(table_abstain[k], xa, cur_alpha);
		end
		if (table_seen[k])
			r = '{table_entropy[k], table_margin[k], table_disagree[k], table_abstain[k], 1'b1};
		else
			r = '0;
		return r;
	endfunction

	function automatic void obs_row(input obs_t o, input logic typed, input avgs_t want);
		row_t r;
		r = '0;
		r.obs = o;
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endfunction

	function automatic void cfg_row(input logic [DATA_W-1:0] v);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.alpha = v;
		directed_rows.push_back(r);
	endfunction

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Random command, concentrated on a few cohorts so that blends pile up.
	function automatic obs_t random_obs();
		obs_t o;
		int   r;
		r = $urandom_range(0, 99);
		if (r < 50)
			o.cmd = CMD_REQUEST;
		else if (r < 80)
			o.cmd = CMD_SHADOW;
		else if (r < 95)
			o.cmd = CMD_READ;
		else
			o.cmd = CMD_UNUSED;
		o.cohort = ($urandom_range(0, 99) < 80) ? COHORT_W'($urandom_range(0, 7)) :
			COHORT_W'($urandom_range(0, 63));
		r = $urandom_range(0, 9);
		o.entropy = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : DATA_W'($urandom);
		r = $urandom_range(0, 9);
		o.margin = (r == 0) ? 16'd0 : (r == 1) ? ONE_Q15 : DATA_W'($urandom_range(0, 32768));
		o.abstained = 1'($urandom_range(0, 1));
		o.champion = DATA_W'($urandom);
		o.challenger = ($urandom_range(0, 1) == 1) ? o.champion : DATA_W'($urandom);
		return o;
	endfunction

	// Presents one command after a gap and waits until the block takes it.
	task automatic send(input obs_t o, input int gap, input logic typed, input avgs_t want);
		avgs_t p;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command <= o.cmd;
		cohort <= o.cohort;
		entropy_in <= o.entropy;
		margin_in <= o.margin;
		abstained <= o.abstained;
		champion_label <= o.champion;
		challenger_label <= o.challenger;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		p = predict_averages(o);
		expected_avgs.push_back(typed ? want : p);
		case (o.cmd)
			CMD_REQUEST: requests_sent++;
			CMD_SHADOW: shadows_sent++;
			default: reads_sent++;
		endcase
	endtask

	// Holds off new commands until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (expected_avgs.size() != 0 || busy);
	endtask

	task automatic set_alpha(input logic [DATA_W-1:0] v);
		drain();
		smoothing_factor_we <= 1'b1;
		smoothing_factor <= v;
		@(posedge clk);
		smoothing_factor_we <= 1'b0;
		cur_alpha = v;
		alpha_writes++;
	endtask

	// Result checker: every done is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		avgs_t want;
		if (arst_n && done) begin
			if (expected_avgs.size() == 0) begin
				$error("result transfer with no command waiting for it");
				errors++;
			end else begin
				want = expected_avgs.pop_front();
				results_checked++;
				if (entropy_avg !== want.entropy) begin
					$error("entropy_avg expected %0d got %0d", want.entropy, entropy_avg);
					errors++;
				end
				if (margin_avg !== want.margin) begin
					$error("margin_avg expected %0d got %0d", want.margin, margin_avg);
					errors++;
				end
				if (disagree_avg !== want.disagree) begin
					$error("disagree_avg expected %0d got %0d", want.disagree, disagree_avg);
					errors++;
				end
				if (abstain_avg !== want.abstain) begin
					$error("abstain_avg expected %0d got %0d", want.abstain, abstain_avg);
					errors++;
				end
				if (seen !== want.seen) begin
					$error("seen expected %0d got %0d", want.seen, seen);
					errors++;
				end
			end
		end
	end

	// Watchdog: too many cycles without any transfer ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [DATA_W-1:0] phase_alpha [7];
		logic [DATA_W-1:0] v;
		int                gap;
		arst_n = 1'b0;
		smoothing_factor_we = 1'b0;
		smoothing_factor = '0;
		start = 1'b0;
		command = CMD_READ;
		cohort = '0;
		entropy_in = '0;
		margin_in = '0;
		abstained = 1'b0;
		champion_label = '0;
		challenger_label = '0;
		for (int i = 0; i < COHORTS; i++) begin
			table_entropy[i] = '0;
			table_margin[i] = '0;
			table_disagree[i] = '0;
			table_abstain[i] = '0;
			table_seen[i] = 1'b0;
		end
		cur_alpha = ALPHA_RESET;
		phase_alpha = '{ALPHA_RESET, ONE_Q15, 16'd0, 16'd1, 16'hFFFF, 16'd16384, 16'd0};

		// Directed table: reset state, first loads, extremes of alpha, blends.
		obs_row(obs_t'{CMD_READ, 6'd0, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 16'd0}, 1'b1, NO_WANT);
		obs_row(obs_t'{CMD_UNUSED, 6'd1, 16'd0, 16'd0, 1'b0, 16'd0, 16'd1}, 1'b1, NO_WANT);
		obs_row(obs_t'{CMD_REQUEST, 6'd2, 16'hFFFF, ONE_Q15, 1'b1, 16'd0, 16'd0}, 1'b1,
			avgs_t'{16'hFFFF, ONE_Q15, 16'd0, ONE_Q15, 1'b1});
		obs_row(obs_t'{CMD_REQUEST, 6'd3, 16'd0, 16'd0, 1'b0, 16'hFFFF, 16'd0}, 1'b1,
			avgs_t'{16'd0, 16'd0, 16'd0, 16'd0, 1'b1});
		obs_row(obs_t'{CMD_SHADOW, 6'd4, 16'hFFFF, ONE_Q15, 1'b1, 16'd0, 16'hFFFF}, 1'b1,
			avgs_t'{16'd0, 16'd0, ONE_Q15, 16'd0, 1'b1});
		obs_row(obs_t'{CMD_SHADOW, 6'd5, 16'd0, 16'd0, 1'b0, 16'hFFFF, 16'hFFFF}, 1'b1,
			avgs_t'{16'd0, 16'd0, 16'd0, 16'd0, 1'b1});
		obs_row(obs_t'{CMD_REQUEST, 6'd2, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0}, 1'b0, NO_WANT);
		obs_row(obs_t'{CMD_SHADOW, 6'd2, 16'd0, 16'd0, 1'b0, 16'd1, 16'd2}, 1'b0, NO_WANT);
		obs_row(obs_t'{CMD_READ, 6'd2, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0}, 1'b0, NO_WANT);
		obs_row(obs_t'{CMD_REQUEST, 6'd63, 16'h1234, 16'h4000, 1'b1, 16'd0, 16'd0}, 1'b1,
			avgs_t'{16'h1234, 16'h4000, 16'd0, ONE_Q15, 1'b1});
		cfg_row(ONE_Q15);
		obs_row(obs_t'{CMD_REQUEST, 6'd2, 16'd4096, 16'd100, 1'b0, 16'd0, 16'd0}, 1'b1,
			avgs_t'{16'd4096, 16'd100, 16'd0, 16'd0, 1'b1});
		obs_row(obs_t'{CMD_SHADOW, 6'd2, 16'hFFFF, 16'd0, 1'b1, 16'd7, 16'd7}, 1'b1,
			avgs_t'{16'd4096, 16'd100, 16'd0, 16'd0, 1'b1});
		cfg_row(16'd0);
		obs_row(obs_t'{CMD_REQUEST, 6'd2, 16'hFFFF, ONE_Q15, 1'b1, 16'd0, 16'd0}, 1'b1,
			avgs_t'{16'd4096, 16'd100, 16'd0, 16'd0, 1'b1});
		cfg_row(16'hFFFF);
		obs_row(obs_t'{CMD_REQUEST, 6'd3, 16'hFFFF, ONE_Q15, 1'b1, 16'd0, 16'd0}, 1'b1,
			avgs_t'{16'hFFFF, ONE_Q15, 16'd0, ONE_Q15, 1'b1});
		cfg_row(16'd1);
		obs_row(obs_t'{CMD_REQUEST, 6'd3, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0}, 1'b0, NO_WANT);
		obs_row(obs_t'{CMD_SHADOW, 6'd3, 16'd0, 16'd0, 1'b0, 16'hAAAA, 16'h5555}, 1'b0,
			NO_WANT);
		cfg_row(ALPHA_RESET);
		obs_row(obs_t'{CMD_READ, 6'd63, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0}, 1'b1,
			avgs_t'{16'h1234, 16'h4000, 16'd0, ONE_Q15, 1'b1});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				set_alpha(directed_rows[i].alpha);
			else
				send(directed_rows[i].obs, $urandom_range(0, 2), directed_rows[i].typed,
					directed_rows[i].want);
		end

		// Random phases, each under its own smoothing factor; the last one is random.
		for (int p = 0; p < 7; p++) begin
			v = (p == 6) ? DATA_W'($urandom) : phase_alpha[p];
			set_alpha(v);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// The full-rate phase runs without any idle cycles.
				gap = (p == 1) ? 0 : pick_gap();
				if (p == 3 && i == 40)
					drain();
				send(random_obs(), gap, 1'b0, NO_WANT);
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d requests, %0d shadow pairs, %0d reads; %0d results checked",
			requests_sent, shadows_sent, reads_sent, results_checked);
		$display("tb: %0d smoothing factor writes, from zero through one to above one",
			alpha_writes);
		if (errors == 0 && expected_avgs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
